// ===== rtl/core/hml_pkg.sv =====
// Shared constants and types for the horizontal mirror line buffer.
// No dependencies; used by the core module and its port checker.
package hml_pkg;

    localparam int LINE_DEPTH = 1920;
    localparam int INDEX_W    = $clog2(LINE_DEPTH);
    localparam int COL_W      = $clog2(LINE_DEPTH + 1);
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [INDEX_W-1:0] LAST_INDEX_RESET = INDEX_W'(LINE_DEPTH - 1);
    localparam logic [COL_W-1:0]   COL_LIMIT        = COL_W'(LINE_DEPTH);
    localparam logic [OCC_W-1:0]   OCC_FULL         = OCC_W'(FIFO_DEPTH);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic   end_of_line;
        logic   start_of_frame;
        pixel_t pixel;
    } result_t;

endpackage

// ===== rtl/core/horizontal_mirror_line_buffer.sv =====
// Horizontal mirror line buffer: two line stores used in ping-pong fashion.
// Depends on hml_pkg for depth, widths and the pixel and result types.
//
// Each accepted pixel is written to the current line store at its column while the
// other store is read at the mirrored column, so every line leaves mirrored and one
// line late. One pixel is taken per clock while s_tready is high; a result goes from
// the registered line store read into the result queue and is offered from there.
// A three-entry result queue decouples the sides, so s_tready is a register and
// stays high under a steady ready from the sink. The first line after reset and any
// column past the previous line's end read as zero; the stores need no clearing
// pass. Columns from LINE_DEPTH on are not stored; start of frame is passed through.
module horizontal_mirror_line_buffer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        s_tlast,   // end_of_line
    input  logic        s_tuser,   // start_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic        m_tlast,   // out_end_of_line
    output logic        m_tuser    // out_start_of_frame
);

    // line stores
    hml_pkg::pixel_t line_store_a_reg [hml_pkg::LINE_DEPTH];
    hml_pkg::pixel_t line_store_b_reg [hml_pkg::LINE_DEPTH];
    hml_pkg::pixel_t rd_a_reg;
    hml_pkg::pixel_t rd_b_reg;

    // line state
    logic [hml_pkg::COL_W-1:0]   column_reg;
    logic [hml_pkg::COL_W-1:0]   column_next;
    logic [hml_pkg::INDEX_W-1:0] last_index_reg;
    logic [hml_pkg::INDEX_W-1:0] last_index_next;
    logic                        bank_reg;
    logic                        bank_next;
    logic                        first_line_reg;
    logic                        first_line_next;

    // read stage
    logic s1_valid_reg;
    logic s1_zero_reg;
    logic s1_bank_reg;
    logic s1_eol_reg;
    logic s1_sof_reg;

    // result queue
    hml_pkg::result_t               fifo_reg [hml_pkg::FIFO_DEPTH];
    logic [hml_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [hml_pkg::FIFO_PTR_W-1:0] wr_ptr_next;
    logic [hml_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [hml_pkg::FIFO_PTR_W-1:0] rd_ptr_next;
    logic [hml_pkg::OCC_W-1:0]      fifo_count_reg;
    logic [hml_pkg::OCC_W-1:0]      fifo_count_next;
    logic [hml_pkg::OCC_W-1:0]      occ_reg;
    logic [hml_pkg::OCC_W-1:0]      occ_next;
    logic                           ready_reg;

    logic                          in_acc;
    logic                          out_acc;
    hml_pkg::pixel_t               in_pixel;
    logic                          col_in_range;
    logic                          mirror_ok;
    logic [hml_pkg::INDEX_W-1:0]   wr_addr;
    logic [hml_pkg::INDEX_W-1:0]   rd_addr;
    logic [hml_pkg::COL_W-1:0]     column_inc;
    hml_pkg::pixel_t               s1_pixel;
    hml_pkg::result_t              s1_result;

    assign in_acc   = s_tvalid && ready_reg;
    assign out_acc  = m_tvalid && m_tready;
    assign s_tready = ready_reg;

    assign in_pixel.red   = s_tdata[7:0];
    assign in_pixel.green = s_tdata[15:8];
    assign in_pixel.blue  = s_tdata[23:16];

    assign col_in_range = column_reg < hml_pkg::COL_LIMIT;
    assign mirror_ok    = column_reg <= {{(hml_pkg::COL_W - hml_pkg::INDEX_W){1'b0}},
                                         last_index_reg};
    assign wr_addr      = column_reg[hml_pkg::INDEX_W-1:0];
    assign rd_addr      = last_index_reg - column_reg[hml_pkg::INDEX_W-1:0];
    assign column_inc   = col_in_range ? column_reg + 1'b1 : column_reg;

    always_comb
    begin
        column_next     = column_reg;
        last_index_next = last_index_reg;
        bank_next       = bank_reg;
        first_line_next = first_line_reg;
        if (in_acc)
        begin
            column_next = column_inc;
            if (s_tlast)
            begin
                // record the line's last index and swap stores
                last_index_next = hml_pkg::INDEX_W'(column_inc - 1'b1);
                column_next     = '0;
                bank_next       = !bank_reg;
                first_line_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && col_in_range && !bank_reg)
        begin
            line_store_a_reg[wr_addr] <= in_pixel;
        end
        if (in_acc)
        begin
            rd_a_reg <= line_store_a_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && col_in_range && bank_reg)
        begin
            line_store_b_reg[wr_addr] <= in_pixel;
        end
        if (in_acc)
        begin
            rd_b_reg <= line_store_b_reg[rd_addr];
        end
    end

    // read stage payload: hold the flags alongside the store read
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_zero_reg <= first_line_reg || !mirror_ok;
            s1_bank_reg <= bank_reg;
            s1_eol_reg  <= s_tlast;
            s1_sof_reg  <= s_tuser;
        end
    end

    assign s1_pixel                 = s1_zero_reg ? '0 : (s1_bank_reg ? rd_a_reg : rd_b_reg);
    assign s1_result.pixel          = s1_pixel;
    assign s1_result.end_of_line    = s1_eol_reg;
    assign s1_result.start_of_frame = s1_sof_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            fifo_reg[wr_ptr_reg] <= s1_result;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (s1_valid_reg)
        begin
            wr_ptr_next = (wr_ptr_reg == hml_pkg::FIFO_PTR_W'(hml_pkg::FIFO_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (out_acc)
        begin
            rd_ptr_next = (rd_ptr_reg == hml_pkg::FIFO_PTR_W'(hml_pkg::FIFO_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        fifo_count_next = fifo_count_reg + hml_pkg::OCC_W'(s1_valid_reg)
                          - hml_pkg::OCC_W'(out_acc);
        // items held in the read stage and the queue together
        occ_next        = occ_reg + hml_pkg::OCC_W'(in_acc) - hml_pkg::OCC_W'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg     <= '0;
            last_index_reg <= hml_pkg::LAST_INDEX_RESET;
            bank_reg       <= 1'b0;
            first_line_reg <= 1'b1;
            s1_valid_reg   <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
            occ_reg        <= '0;
            ready_reg      <= 1'b1;
        end
        else
        begin
            column_reg     <= column_next;
            last_index_reg <= last_index_next;
            bank_reg       <= bank_next;
            first_line_reg <= first_line_next;
            s1_valid_reg   <= in_acc;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fifo_count_reg <= fifo_count_next;
            occ_reg        <= occ_next;
            ready_reg      <= occ_next != hml_pkg::OCC_FULL;
        end
    end

    assign m_tvalid = fifo_count_reg != '0;
    assign m_tdata  = {fifo_reg[rd_ptr_reg].pixel.blue,
                       fifo_reg[rd_ptr_reg].pixel.green,
                       fifo_reg[rd_ptr_reg].pixel.red};
    assign m_tlast  = fifo_reg[rd_ptr_reg].end_of_line;
    assign m_tuser  = fifo_reg[rd_ptr_reg].start_of_frame;

endmodule

// ===== rtl/core/hml_port_checker.sv =====
// Port-level checks for the horizontal mirror line buffer, bound to the top level.
// Depends on hml_pkg for the queue depth.
module hml_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    logic [hml_pkg::OCC_W-1:0] pending_reg;
    logic                      in_acc;
    logic                      out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // count requests taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + hml_pkg::OCC_W'(in_acc)
                           - hml_pkg::OCC_W'(out_acc);
        end
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result changed");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != '0)
        else $error("result without a pending request");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pending_reg != hml_pkg::OCC_FULL)
        else $error("request taken with all slots in use");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (pending_reg != hml_pkg::OCC_FULL) |-> s_tready)
        else $error("input stalled with free slots");

endmodule

bind horizontal_mirror_line_buffer hml_port_checker u_hml_port_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for horizontal_mirror_line_buffer (ping-pong line mirror).
// Depends on hml_pkg for the depth, widths and pixel type, and on the RTL top.
// A directed pixel table runs first, then a long line and random lines vs. a line predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_PERIOD  = 12;
    localparam int RAND_PIXELS = 500;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit       eol;
        bit       sof;
        bit       typed;
        bit [7:0] exp_red;
        bit [7:0] exp_green;
        bit [7:0] exp_blue;
    } script_row_t;

    typedef struct {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit       sof;
        bit       eol;
    } mirrored_px_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // Predictor state: two line stores, write column, previous line's last index, bank
    hml_pkg::pixel_t                 line_a [hml_pkg::LINE_DEPTH];
    hml_pkg::pixel_t                 line_b [hml_pkg::LINE_DEPTH];
    logic [hml_pkg::COL_W-1:0]       write_col;
    logic [hml_pkg::INDEX_W-1:0]     prev_last;
    bit                              write_b;

    mirrored_px_t pending_px [$];
    int           fail_count = 0;
    int           shown      = 0;
    int           rand_sent  = 0;
    bit           calm       = 1'b0;
    bit           sink_hold  = 1'b0;

    // The first line reads zeros; typed rows expect black at columns past the previous end
    script_row_t pixel_script [0:19] = '{
        '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'h12, 8'h34, 8'h56, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'hA5, 8'h5A, 8'hC3, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'h80, 8'h7F, 8'h01, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h80, 8'h7F, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'hFE, 8'hEF, 8'h10, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h33, 8'hCC, 8'h55, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'h0F, 8'hF0, 8'hAA, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'h5A, 8'hA5, 8'h3C, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'hC3, 8'h3C, 8'h99, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h11, 8'h22, 8'h33, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h55, 8'h66, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'h77, 8'h88, 8'h99, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'hAB, 8'hCD, 8'hEF, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
        '{8'h10, 8'h20, 8'h30, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00}
    };

    horizontal_mirror_line_buffer dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Read the mirrored column of the previous line, store the new pixel, advance the column
    function automatic mirrored_px_t mirror_step(hml_pkg::pixel_t px, bit eol, bit sof);
        mirrored_px_t    res;
        hml_pkg::pixel_t rd;
        logic [hml_pkg::INDEX_W-1:0] idx;
        rd = '0;
        if (write_col <= prev_last)
        begin
            idx = prev_last - write_col[hml_pkg::INDEX_W-1:0];
            rd  = write_b ? line_a[idx] : line_b[idx];
        end
        if (write_col < hml_pkg::COL_LIMIT)
        begin
            if (write_b)
                line_b[write_col] = px;
            else
                line_a[write_col] = px;
            write_col = write_col + 1'b1;
        end
        res.red   = rd.red;
        res.green = rd.green;
        res.blue  = rd.blue;
        res.sof   = sof;
        res.eol   = eol;
        if (eol)
        begin
            prev_last = hml_pkg::INDEX_W'(write_col - 1'b1);
            write_col = '0;
            write_b   = ~write_b;
        end
        return res;
    endfunction

    task automatic send_pixel(input hml_pkg::pixel_t px, input bit eol, input bit sof,
                              input bit typed, input mirrored_px_t typed_res);
        mirrored_px_t res;
        if (!calm && $urandom_range(0, 99) < 14)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= eol;
        s_tuser  <= sof;
        do
            @(posedge clk);
        while (!s_tready);
        res = mirror_step(px, eol, sof);
        pending_px.push_back(typed ? typed_res : res);
    endtask

    task automatic send_line(input int len);
        hml_pkg::pixel_t px;
        mirrored_px_t    none;
        bit              sof;
        none = '{default: 0};
        for (int i = 0; i < len; i++)
        begin
            px.red   = 8'($urandom_range(0, 255));
            px.green = 8'($urandom_range(0, 255));
            px.blue  = 8'($urandom_range(0, 255));
            // occasional frame starts on the first pixel, plus stray flags on any pixel
            sof = (i == 0 && $urandom_range(0, 7) == 0) || $urandom_range(0, 19) == 0;
            send_pixel(px, i == len - 1, sof, 1'b0, none);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        hml_pkg::pixel_t px;
        mirrored_px_t    typed_res;
        int              len;
        int              calm_end;
        bit              paused;
        for (int i = 0; i < hml_pkg::LINE_DEPTH; i++)
        begin
            line_a[i] = '0;
            line_b[i] = '0;
        end
        write_col = '0;
        prev_last = hml_pkg::LAST_INDEX_RESET;
        write_b   = 1'b0;
        paused    = 1'b0;
        calm_end  = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (pixel_script[i])
        begin
            px.red          = pixel_script[i].red;
            px.green        = pixel_script[i].green;
            px.blue         = pixel_script[i].blue;
            typed_res.red   = pixel_script[i].exp_red;
            typed_res.green = pixel_script[i].exp_green;
            typed_res.blue  = pixel_script[i].exp_blue;
            typed_res.sof   = pixel_script[i].sof;
            typed_res.eol   = pixel_script[i].eol;
            send_pixel(px, pixel_script[i].eol, pixel_script[i].sof,
                       pixel_script[i].typed, typed_res);
        end
        drain_results();

        // Overlong line: column saturates, tail pixels dropped, then read back mirrored
        send_line(hml_pkg::LINE_DEPTH + 2);

        while (rand_sent < RAND_PIXELS)
        begin
            // one stretch of about 150 pixels with no idling on either side
            if (calm_end == 0 && rand_sent >= 200)
                calm_end = rand_sent + 150;
            calm = rand_sent < calm_end;
            if (!paused && rand_sent >= 400)
            begin
                drain_results();
                paused = 1'b1;
            end
            case ($urandom_range(0, 99)) inside
                [0:74]:  len = $urandom_range(1, 24);
                [75:94]: len = $urandom_range(25, 160);
                default: len = $urandom_range(161, 400);
            endcase
            send_line(len);
            rand_sent += len;
        end
        calm = 1'b0;

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_px.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Sink: random back-pressure, held off entirely while sink_hold is set
    initial
    begin
        mirrored_px_t exp_px;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_px.size() == 0)
                begin
                    fail_count++;
                    if (shown < MAX_SHOWN)
                        $display("unexpected result tdata=%h tlast=%b tuser=%b",
                                 m_tdata, m_tlast, m_tuser);
                    shown++;
                end
                else
                begin
                    exp_px = pending_px.pop_front();
                    if (m_tdata[7:0] !== exp_px.red || m_tdata[15:8] !== exp_px.green ||
                        m_tdata[23:16] !== exp_px.blue || m_tlast !== exp_px.eol ||
                        m_tuser !== exp_px.sof)
                    begin
                        fail_count++;
                        if (shown < MAX_SHOWN)
                            $display("mismatch: exp rgb=%h%h%h eol=%b sof=%b, %s",
                                     exp_px.red, exp_px.green, exp_px.blue, exp_px.eol,
                                     exp_px.sof,
                                     $sformatf("got rgb=%h%h%h eol=%b sof=%b",
                                               m_tdata[7:0], m_tdata[15:8],
                                               m_tdata[23:16], m_tlast, m_tuser));
                        shown++;
                    end
                end
            end
            if (sink_hold)
                m_tready <= 1'b0;
            else
                m_tready <= calm || $urandom_range(0, 99) >= 18;
        end
    end

    // Hold the sink off long enough for the block to fill and stall its input
    initial
    begin
        while (rand_sent < 100)
            @(posedge clk);
        sink_hold <= 1'b1;
        repeat (150) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial
    begin
        #(CLK_PERIOD * 300000);
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hml_pkg.sv
rtl/core/horizontal_mirror_line_buffer.sv
rtl/core/hml_port_checker.sv
dv/tb_top.sv
